### hdl/rrip_pkg.sv
// ----------------------------------------------------------------------------
// RUN/RESET interlock pulser package
// Shared widths, command and status codes, and the per-line command bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package rrip_pkg;

  localparam int unsigned TimerBitsDef = 31;
  localparam int unsigned DurW         = 31;
  localparam int unsigned OpW          = 3;
  localparam int unsigned StatusW      = 2;

  typedef enum logic [OpW-1:0] {
    OP_TICK        = 3'd0,
    OP_RUN_LATCH   = 3'd1,
    OP_RESET_LATCH = 3'd2,
    OP_POWER       = 3'd3,
    OP_RUN_PULSE   = 3'd4,
    OP_RESET_PULSE = 3'd5
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 2'd0,
    ST_DENIED  = 2'd1,
    ST_ZERO    = 2'd2,
    ST_INVALID = 2'd3
  } status_e;

  // Decoded command for one control line.
  typedef struct packed {
    logic tick;
    logic latch;
    logic pulse;
    logic active;
  } line_cmd_t;

endpackage

`default_nettype wire

### hdl/rrip_intf.sv
// ----------------------------------------------------------------------------
// RUN/RESET interlock pulser channels
// Valid/ready channels for commands and for status results.
// ----------------------------------------------------------------------------
`default_nettype none

interface rrip_in_if;
  logic                     valid;
  logic                     ready;
  logic [rrip_pkg::OpW-1:0]  opcode;
  logic                     active;
  logic [rrip_pkg::DurW-1:0] duration;

  modport source (output valid, opcode, active, duration, input ready);
  modport sink   (input valid, opcode, active, duration, output ready);
endinterface

interface rrip_out_if;
  logic                        valid;
  logic                        ready;
  logic [rrip_pkg::StatusW-1:0] status;
  logic                        run_line_low;
  logic                        reset_line_low;
  logic                        power_enabled;
  logic                        run_pulsing;
  logic                        reset_pulsing;
  logic                        run_pulse_done;
  logic                        reset_pulse_done;

  modport source (output valid, status, run_line_low, reset_line_low, power_enabled,
                  run_pulsing, reset_pulsing, run_pulse_done, reset_pulse_done,
                  input ready);
  modport sink   (input valid, status, run_line_low, reset_line_low, power_enabled,
                  run_pulsing, reset_pulsing, run_pulse_done, reset_pulse_done,
                  output ready);
endinterface

`default_nettype wire

### hdl/rrip_line.sv
// ----------------------------------------------------------------------------
// RUN/RESET interlock pulser line controller
// Latch, pulse timer and interlock check for one active-low control line.
// ----------------------------------------------------------------------------
`default_nettype none

module rrip_line #(
  parameter int unsigned TimerBits = rrip_pkg::TimerBitsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire rrip_pkg::line_cmd_t  cmd_i,
  input  wire logic [TimerBits-1:0] dur_i,
  input  wire logic                 other_low_i,
  output logic                      low_o,
  output logic                      next_low_o,
  output logic                      next_pulse_o,
  output logic                      done_o,
  output logic                      deny_o
);
  import rrip_pkg::*;

  logic                 held_q, held_d;
  logic                 pulse_q, pulse_d;
  logic [TimerBits-1:0] ticks_q, ticks_d;

  always_comb begin
    held_d  = held_q;
    pulse_d = pulse_q;
    ticks_d = ticks_q;
    done_o  = 1'b0;
    deny_o  = 1'b0;
    if (cmd_i.tick) begin
      if (pulse_q) begin
        if (ticks_q <= TimerBits'(1)) begin
          pulse_d = 1'b0;
          ticks_d = '0;
          done_o  = ~held_q;
        end else begin
          ticks_d = ticks_q - TimerBits'(1);
        end
      end
    end else if (cmd_i.latch) begin
      if (cmd_i.active && other_low_i) begin
        deny_o = 1'b1;
      end else begin
        held_d = cmd_i.active;
        if (!cmd_i.active) begin
          pulse_d = 1'b0;
          ticks_d = '0;
        end
      end
    end else if (cmd_i.pulse) begin
      if (other_low_i) begin
        deny_o = 1'b1;
      end else begin
        pulse_d = 1'b1;
        ticks_d = dur_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= 1'b0;
      pulse_q <= 1'b0;
      ticks_q <= '0;
    end else if (en_i) begin
      held_q  <= held_d;
      pulse_q <= pulse_d;
      ticks_q <= ticks_d;
    end
  end

  assign low_o        = held_q | pulse_q;
  assign next_low_o   = held_d | pulse_d;
  assign next_pulse_o = pulse_d;

endmodule

`default_nettype wire

### hdl/run_reset_interlock_pulser.sv
// A command passes two register stages, input and result, to the output channel.
// Throughput: one command per cycle while the output channel is not stalled; each
// command is a single register update of the two line controllers and the power
// bit, with no loop between commands.
// Reset: rst_ni clears all latches, pulse timers, power and valid flags at once.
// ----------------------------------------------------------------------------
// RUN/RESET interlock pulser
// Decodes commands, drives two interlocked line controllers and a power bit.
// ----------------------------------------------------------------------------
`default_nettype none

module run_reset_interlock_pulser #(
  parameter int unsigned TimerBits = rrip_pkg::TimerBitsDef
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  rrip_in_if.sink     in_i,
  rrip_out_if.source  out_o
);
  import rrip_pkg::*;

  localparam logic [32:0] TimerMax = 33'((64'd1 << TimerBits) - 64'd1);

  // Input register.
  logic            in_valid_q;
  logic [OpW-1:0]  op_q;
  logic            active_q;
  logic [DurW-1:0] dur_q;

  // Result register.
  logic               out_valid_q;
  logic [StatusW-1:0] status_q;
  logic               run_low_q, rst_low_q, power_out_q;
  logic               run_pulse_q, rst_pulse_q, run_done_q, rst_done_q;

  logic power_q, power_d;
  logic advance, exec;

  line_cmd_t            run_cmd, rst_cmd;
  logic [32:0]          dur_ext;
  logic [TimerBits-1:0] dur_sat;
  status_e              status_d;

  logic run_low, rst_low, run_next_low, rst_next_low;
  logic run_next_pulse, rst_next_pulse, run_done, rst_done, run_deny, rst_deny;
  logic dur_zero;

  assign advance    = ~out_valid_q | out_o.ready;
  assign exec       = in_valid_q & advance;
  assign in_i.ready = ~in_valid_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      op_q     <= in_i.opcode;
      active_q <= in_i.active;
      dur_q    <= in_i.duration;
    end
  end

  // Durations beyond the timer saturate to its largest count.
  assign dur_ext  = 33'(dur_q);
  assign dur_sat  = (dur_ext > TimerMax) ? TimerMax[TimerBits-1:0]
                                         : dur_ext[TimerBits-1:0];
  assign dur_zero = (dur_q == '0);

  always_comb begin
    run_cmd  = '0;
    rst_cmd  = '0;
    power_d  = power_q;
    run_cmd.active = active_q;
    rst_cmd.active = active_q;
    case (op_q)
      OP_TICK: begin
        run_cmd.tick = 1'b1;
        rst_cmd.tick = 1'b1;
      end
      OP_RUN_LATCH:   run_cmd.latch = 1'b1;
      OP_RESET_LATCH: rst_cmd.latch = 1'b1;
      OP_POWER:       power_d = active_q;
      OP_RUN_PULSE:   run_cmd.pulse = ~dur_zero;
      OP_RESET_PULSE: rst_cmd.pulse = ~dur_zero;
      default: ;
    endcase
  end

  always_comb begin
    case (op_q)
      OP_TICK, OP_POWER: status_d = ST_OK;
      OP_RUN_LATCH, OP_RESET_LATCH: begin
        status_d = (run_deny | rst_deny) ? ST_DENIED : ST_OK;
      end
      OP_RUN_PULSE, OP_RESET_PULSE: begin
        if (dur_zero) begin
          status_d = ST_ZERO;
        end else begin
          status_d = (run_deny | rst_deny) ? ST_DENIED : ST_OK;
        end
      end
      default: status_d = ST_INVALID;
    endcase
  end

  rrip_line #(.TimerBits(TimerBits)) u_run_line (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (exec),
    .cmd_i        (run_cmd),
    .dur_i        (dur_sat),
    .other_low_i  (rst_low),
    .low_o        (run_low),
    .next_low_o   (run_next_low),
    .next_pulse_o (run_next_pulse),
    .done_o       (run_done),
    .deny_o       (run_deny)
  );

  rrip_line #(.TimerBits(TimerBits)) u_rst_line (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (exec),
    .cmd_i        (rst_cmd),
    .dur_i        (dur_sat),
    .other_low_i  (run_low),
    .low_o        (rst_low),
    .next_low_o   (rst_next_low),
    .next_pulse_o (rst_next_pulse),
    .done_o       (rst_done),
    .deny_o       (rst_deny)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (exec) begin
        power_q <= power_d;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      status_q    <= status_d;
      run_low_q   <= run_next_low;
      rst_low_q   <= rst_next_low;
      power_out_q <= power_d;
      run_pulse_q <= run_next_pulse;
      rst_pulse_q <= rst_next_pulse;
      run_done_q  <= run_done;
      rst_done_q  <= rst_done;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.status           = status_q;
  assign out_o.run_line_low     = run_low_q;
  assign out_o.reset_line_low   = rst_low_q;
  assign out_o.power_enabled    = power_out_q;
  assign out_o.run_pulsing      = run_pulse_q;
  assign out_o.reset_pulsing    = rst_pulse_q;
  assign out_o.run_pulse_done   = run_done_q;
  assign out_o.reset_pulse_done = rst_done_q;

`ifndef NO_ASSERTIONS
  // The interlock never lets both lines be driven at once.
  a_interlock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(run_low && rst_low))
    else $error("RUN and RESET driven low together");

  // A finished RUN pulse leaves the line released and idle.
  a_run_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.run_pulse_done) |-> (!out_o.run_pulsing && !out_o.run_line_low))
    else $error("RUN pulse done while line still driven");

  a_rst_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.reset_pulse_done) |->
      (!out_o.reset_pulsing && !out_o.reset_line_low))
    else $error("RESET pulse done while line still driven");

  // Only a tick can raise a pulse done flag.
  a_done_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec && (op_q != OP_TICK)) |-> (!run_done && !rst_done))
    else $error("Pulse done flag on a non-tick command");
`endif

endmodule

`default_nettype wire
